// File: rtl/core/hdp_pkg.sv
// Shared types, format codes and signature tables for the picture header parser.
// Used by every module of the parser; depends on nothing else.
`timescale 1ns / 1ps

package hdp_pkg;

    typedef enum logic [1:0] {
        KIND_JPEG = 2'd0,
        KIND_PNG  = 2'd1,
        KIND_GIF  = 2'd2,
        KIND_BMP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic        found;
        logic [30:0] width;
        logic [30:0] height;
    } t_outcome;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] data;
    } t_beat_ctl;

    localparam logic [7:0] BMP_SIG0 = 8'h42;
    localparam logic [7:0] BMP_SIG1 = 8'h4D;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4E;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0D;
            3'd5: v = 8'h0A;
            3'd6: v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] png_ihdr_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0: v = 8'h49;
            2'd1: v = 8'h48;
            2'd2: v = 8'h44;
            default: v = 8'h52;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] gif_sig_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0: v = 8'h47;
            2'd1: v = 8'h49;
            2'd2: v = 8'h46;
            default: v = 8'h38;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/hdp_jpeg_walker.sv
// JPEG marker walker: checks SOI, skips segments and captures the first frame size.
// Depends on hdp_pkg for the beat control and outcome types.
`timescale 1ns / 1ps

module hdp_jpeg_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hdp_pkg::t_beat_ctl i_ctl,
    output hdp_pkg::t_outcome  o_outcome
);
    import hdp_pkg::*;

    typedef enum logic [9:0] {
        PH_SEEK_SOI = 10'b0000000001,
        PH_SOI2     = 10'b0000000010,
        PH_SCAN     = 10'b0000000100,
        PH_MARKER   = 10'b0000001000,
        PH_LEN_HI   = 10'b0000010000,
        PH_LEN_LO   = 10'b0000100000,
        PH_SKIP     = 10'b0001000000,
        PH_SOF      = 10'b0010000000,
        PH_DONE     = 10'b0100000000,
        PH_FAIL     = 10'b1000000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic [3:0]  r_seg_off, n_seg_off;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_done, n_done;
    logic [15:0] seg_len;
    logic [3:0]  seg_inc;
    logic        is_standalone;
    logic        is_sof;
    logic [7:0]  b;

    assign b       = i_ctl.data;
    assign seg_len = {r_skip[15:8], b};
    assign seg_inc = r_seg_off + 4'd1;
    assign is_standalone = (b == 8'hD8) || (b == 8'h01) || (b >= 8'hD0 && b <= 8'hD7);
    assign is_sof = (b >= 8'hC0) && (b <= 8'hCF) && (b != 8'hC4) && (b != 8'hC8)
                    && (b != 8'hCC);

    always_comb begin
        n_phase   = r_phase;
        n_skip    = r_skip;
        n_seg_off = r_seg_off;
        n_width   = r_width;
        n_height  = r_height;
        n_done    = r_done;
        case (r_phase)
            PH_SEEK_SOI: n_phase = (b == 8'hFF) ? PH_SOI2 : PH_FAIL;
            PH_SOI2:     n_phase = (b == 8'hD8) ? PH_SCAN : PH_FAIL;
            PH_SCAN: begin
                if (b == 8'hFF) begin
                    n_phase = PH_MARKER;
                end
            end
            PH_MARKER: begin
                if (b != 8'hFF) begin
                    if (is_standalone) begin
                        n_phase = PH_SCAN;
                    end else begin
                        n_seg_off = 4'd0;
                        n_phase   = is_sof ? PH_SOF : PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                n_skip  = {b, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (seg_len < 16'd2) begin
                    n_phase = PH_FAIL;
                end else begin
                    n_skip  = seg_len - 16'd2;
                    n_phase = (seg_len != 16'd2) ? PH_SKIP : PH_SCAN;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (r_skip == 16'd1) begin
                    n_phase = PH_SCAN;
                end
            end
            PH_SOF: begin
                n_seg_off = seg_inc;
                case (seg_inc)
                    4'd4: n_height = {b, 8'h00};
                    4'd5: n_height = {r_height[15:8], b};
                    4'd6: n_width  = {b, 8'h00};
                    4'd7: n_width  = {r_width[15:8], b};
                    4'd8: begin
                        n_done  = 1'b1;
                        n_phase = PH_DONE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear) || (!i_ctl.step && i_ctl.clear)) begin
            r_phase   <= PH_SEEK_SOI;
            r_skip    <= 16'd0;
            r_seg_off <= 4'd0;
            r_width   <= 16'd0;
            r_height  <= 16'd0;
            r_done    <= 1'b0;
        end else if (i_ctl.step) begin
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_seg_off <= n_seg_off;
            r_width   <= n_width;
            r_height  <= n_height;
            r_done    <= n_done;
        end
    end

    assign o_outcome.found  = n_done && (n_width != 16'd0) && (n_height != 16'd0);
    assign o_outcome.width  = {15'd0, n_width};
    assign o_outcome.height = {15'd0, n_height};

endmodule

// File: rtl/core/hdp_fixed_fields.sv
// Fixed-offset field reader for PNG, GIF and BMP headers with a saturating byte index.
// Depends on hdp_pkg for the format codes, signature tables and outcome type.
`timescale 1ns / 1ps

module hdp_fixed_fields (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hdp_pkg::t_kind     i_kind,
    input  hdp_pkg::t_beat_ctl i_ctl,
    output hdp_pkg::t_outcome  o_outcome
);
    import hdp_pkg::*;

    logic [4:0]  r_count, n_count;
    logic        r_fail, n_fail;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [31:0] bmp_habs;
    logic [7:0]  b;
    logic [4:0]  idx;

    assign b   = i_ctl.data;
    assign idx = r_count;
    assign n_count = (r_count != 5'd31) ? r_count + 5'd1 : r_count;

    always_comb begin
        n_fail   = r_fail;
        n_width  = r_width;
        n_height = r_height;
        if (!r_fail) begin
            case (i_kind)
                KIND_PNG: begin
                    if (idx < 5'd8) begin
                        n_fail = (b != png_sig_byte(idx[2:0]));
                    end else if (idx >= 5'd12 && idx < 5'd16) begin
                        n_fail = (b != png_ihdr_byte(idx[1:0]));
                    end else if (idx >= 5'd16 && idx < 5'd20) begin
                        n_width = {r_width[23:0], b};
                    end else if (idx >= 5'd20 && idx < 5'd24) begin
                        n_height = {r_height[23:0], b};
                    end
                end
                KIND_GIF: begin
                    case (idx)
                        5'd0, 5'd1, 5'd2, 5'd3: n_fail = (b != gif_sig_byte(idx[1:0]));
                        5'd6: n_width  = {24'd0, b};
                        5'd7: n_width  = r_width | {16'd0, b, 8'd0};
                        5'd8: n_height = {24'd0, b};
                        5'd9: n_height = r_height | {16'd0, b, 8'd0};
                        default: ;
                    endcase
                end
                KIND_BMP: begin
                    case (idx)
                        5'd0:  n_fail = (b != BMP_SIG0);
                        5'd1:  n_fail = (b != BMP_SIG1);
                        5'd18: n_width[7:0]    = r_width[7:0] | b;
                        5'd19: n_width[15:8]   = r_width[15:8] | b;
                        5'd20: n_width[23:16]  = r_width[23:16] | b;
                        5'd21: n_width[31:24]  = r_width[31:24] | b;
                        5'd22: n_height[7:0]   = r_height[7:0] | b;
                        5'd23: n_height[15:8]  = r_height[15:8] | b;
                        5'd24: n_height[23:16] = r_height[23:16] | b;
                        5'd25: n_height[31:24] = r_height[31:24] | b;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count  <= 5'd0;
            r_fail   <= 1'b0;
            r_width  <= 32'd0;
            r_height <= 32'd0;
        end else if (i_ctl.step) begin
            r_count  <= n_count;
            r_fail   <= n_fail;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign bmp_habs = n_height[31] ? (32'd0 - n_height) : n_height;

    always_comb begin
        o_outcome.width = n_width[30:0];
        case (i_kind)
            KIND_PNG: begin
                o_outcome.found  = !n_fail && (n_count >= 5'd24) && (n_width != 32'd0)
                                   && !n_width[31] && (n_height != 32'd0) && !n_height[31];
                o_outcome.height = n_height[30:0];
            end
            KIND_GIF: begin
                o_outcome.found  = !n_fail && (n_count >= 5'd10) && (n_width != 32'd0)
                                   && (n_height != 32'd0);
                o_outcome.height = n_height[30:0];
            end
            KIND_BMP: begin
                o_outcome.found  = !n_fail && (n_count >= 5'd26) && (n_width != 32'd0)
                                   && !n_width[31] && (bmp_habs != 32'd0) && !bmp_habs[31];
                o_outcome.height = bmp_habs[30:0];
            end
            default: begin
                o_outcome.found  = 1'b0;
                o_outcome.height = n_height[30:0];
            end
        endcase
    end

endmodule

// File: rtl/core/image_header_dimension_parser_top.sv
// Path: each accepted byte waits in the input register; a final byte then loads the result register.
// Throughput: one byte beat per cycle; a final byte waits in the input register only
// while the result register is still full and not being taken.
// Reset: synchronous, active low; clears the picture state, the kind to JPEG and
// both handshake registers. A configuration write restarts the picture.
// Depends on hdp_pkg, hdp_jpeg_walker and hdp_fixed_fields.
`timescale 1ns / 1ps

module image_header_dimension_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,       // image_kind
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // data_byte
    input  logic        s_axis_tlast,     // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,     // width [30:0], height [61:31], zero fill
    output logic        m_axis_tuser      // found
);
    import hdp_pkg::*;

    t_kind      r_kind;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_m_valid;
    t_outcome   r_result;
    logic       advance;
    logic       cfg_fire;
    t_beat_ctl  ctl;
    t_outcome   jpeg_outcome;
    t_outcome   fixed_outcome;
    t_outcome   sel_outcome;

    assign o_cfg_ready   = 1'b1;
    assign cfg_fire      = i_cfg_valid;
    assign advance       = r_in_valid && (!r_in_last || !r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign ctl.step  = advance;
    assign ctl.clear = cfg_fire || (advance && r_in_last);
    assign ctl.data  = r_in_byte;

    hdp_jpeg_walker u_jpeg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_outcome (jpeg_outcome)
    );

    hdp_fixed_fields u_fixed (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kind    (r_kind),
        .i_ctl     (ctl),
        .o_outcome (fixed_outcome)
    );

    always_comb begin
        sel_outcome = (r_kind == KIND_JPEG) ? jpeg_outcome : fixed_outcome;
        if (!sel_outcome.found) begin
            sel_outcome.width  = 31'd0;
            sel_outcome.height = 31'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_JPEG;
        end else if (cfg_fire) begin
            r_kind <= t_kind'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_result <= sel_outcome;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_result.height, r_result.width};
    assign m_axis_tuser  = r_result.found;

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_result.found) |-> (r_result.width == 31'd0
                                             && r_result.height == 31'd0))
        else $error("failed result carries nonzero dimensions");

    a_last_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> r_m_valid)
        else $error("final byte did not load the result register");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)
                                      && $stable(r_in_last)))
        else $error("stalled input beat was lost or overwritten");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_m_valid && !m_axis_tready) |-> !advance)
        else $error("result register overrun");

endmodule

// File: tb/image_header_dimension_parser_top_test.sv
// Self-checking bench for image_header_dimension_parser_top: streams JPEG, PNG, GIF and BMP
// pictures byte by byte and compares every result beat against a cycle-free model.
// Depends on hdp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module image_header_dimension_parser_top_test;
    import hdp_pkg::*;

    localparam logic [7:0]  MK_PREFIX    = 8'hFF;
    localparam logic [7:0]  MK_SOI       = 8'hD8;
    localparam logic [7:0]  MK_TEM       = 8'h01;
    localparam logic [7:0]  MK_RST_FIRST = 8'hD0;
    localparam logic [7:0]  MK_RST_LAST  = 8'hD7;
    localparam logic [7:0]  MK_SOF_FIRST = 8'hC0;
    localparam logic [7:0]  MK_SOF_LAST  = 8'hCF;
    localparam logic [7:0]  MK_DHT       = 8'hC4;
    localparam logic [7:0]  MK_JPG_EXT   = 8'hC8;
    localparam logic [7:0]  MK_DAC       = 8'hCC;
    localparam logic [7:0]  MK_DQT       = 8'hDB;
    localparam logic [7:0]  MK_COM       = 8'hFE;
    localparam logic [7:0]  MK_APP0      = 8'hE0;
    localparam logic [63:0] PNG_SIG      = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] PNG_IHDR     = 32'h4948_4452;
    localparam logic [31:0] GIF_MAGIC    = 32'h4749_4638;
    localparam logic [15:0] BMP_MAGIC    = 16'h424D;
    localparam int          STIM_BYTES   = 1850;
    localparam int          SETTLE_CYCLES = 6;

    typedef enum logic [3:0] {
        SC_SEEK_SOI, SC_SOI2, SC_SCAN, SC_MARKER, SC_LEN_HI,
        SC_LEN_LO, SC_SKIP, SC_SOF, SC_DONE, SC_FAIL
    } t_scan;

    class dim_scoreboard;
        t_kind       kind;
        logic [4:0]  seen;
        t_scan       phase;
        logic [16:0] skip_left;
        logic [3:0]  sof_pos;
        logic [31:0] wacc;
        logic [31:0] hacc;
        bit          sof_done;
        t_outcome    expected_dims[$];
        int          errors;
        int          pictures;
        int          found_count;

        function new();
            kind = KIND_JPEG;
            errors = 0;
            pictures = 0;
            found_count = 0;
            clear_picture();
        endfunction

        function void clear_picture();
            seen = '0;
            phase = SC_SEEK_SOI;
            skip_left = '0;
            sof_pos = '0;
            wacc = '0;
            hacc = '0;
            sof_done = 1'b0;
        endfunction

        function void set_kind(t_kind k);
            kind = k;
            clear_picture();
        endfunction

        function void jpeg_step(logic [7:0] b);
            logic [15:0] seg_len;
            case (phase)
                SC_SEEK_SOI: phase = (b == MK_PREFIX) ? SC_SOI2 : SC_FAIL;
                SC_SOI2:     phase = (b == MK_SOI) ? SC_SCAN : SC_FAIL;
                SC_SCAN: begin
                    if (b == MK_PREFIX) phase = SC_MARKER;
                end
                SC_MARKER: begin
                    if (b != MK_PREFIX) begin
                        if (b == MK_SOI || b == MK_TEM || (b >= MK_RST_FIRST && b <= MK_RST_LAST)) begin
                            phase = SC_SCAN;
                        end else begin
                            sof_pos = '0;
                            if (b >= MK_SOF_FIRST && b <= MK_SOF_LAST && b != MK_DHT
                                && b != MK_JPG_EXT && b != MK_DAC)
                                phase = SC_SOF;
                            else
                                phase = SC_LEN_HI;
                        end
                    end
                end
                SC_LEN_HI: begin
                    skip_left = {1'b0, b, 8'h00};
                    phase = SC_LEN_LO;
                end
                SC_LEN_LO: begin
                    seg_len = {skip_left[15:8], b};
                    if (seg_len < 16'd2) begin
                        phase = SC_FAIL;
                    end else begin
                        skip_left = {1'b0, seg_len - 16'd2};
                        phase = (skip_left != 0) ? SC_SKIP : SC_SCAN;
                    end
                end
                SC_SKIP: begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == 0) phase = SC_SCAN;
                end
                SC_SOF: begin
                    sof_pos = sof_pos + 4'd1;
                    case (sof_pos)
                        4'd4: hacc = {16'h0, b, 8'h00};
                        4'd5: hacc = hacc | {24'h0, b};
                        4'd6: wacc = {16'h0, b, 8'h00};
                        4'd7: wacc = wacc | {24'h0, b};
                        4'd8: begin
                            sof_done = 1'b1;
                            phase = SC_DONE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic is_last);
            int          i;
            logic [31:0] habs;
            logic        ok;
            t_outcome    r;
            i = seen;
            if (seen != 5'd31) seen = seen + 5'd1;
            case (kind)
                KIND_JPEG: jpeg_step(b);
                KIND_PNG: begin
                    if (phase != SC_FAIL) begin
                        if (i < 8) begin
                            if (b != PNG_SIG[63 - 8 * i -: 8]) phase = SC_FAIL;
                        end else if (i >= 12 && i < 16) begin
                            if (b != PNG_IHDR[31 - 8 * (i - 12) -: 8]) phase = SC_FAIL;
                        end else if (i >= 16 && i < 20) begin
                            wacc = {wacc[23:0], b};
                        end else if (i >= 20 && i < 24) begin
                            hacc = {hacc[23:0], b};
                        end
                    end
                end
                KIND_GIF: begin
                    if (phase != SC_FAIL) begin
                        if (i < 4) begin
                            if (b != GIF_MAGIC[31 - 8 * i -: 8]) phase = SC_FAIL;
                        end else if (i == 6) wacc = {24'h0, b};
                        else if (i == 7) wacc = wacc | {16'h0, b, 8'h00};
                        else if (i == 8) hacc = {24'h0, b};
                        else if (i == 9) hacc = hacc | {16'h0, b, 8'h00};
                    end
                end
                default: begin
                    if (phase != SC_FAIL) begin
                        if (i < 2) begin
                            if (b != BMP_MAGIC[15 - 8 * i -: 8]) phase = SC_FAIL;
                        end else if (i >= 18 && i < 22) begin
                            wacc = wacc | ({24'h0, b} << (8 * (i - 18)));
                        end else if (i >= 22 && i < 26) begin
                            hacc = hacc | ({24'h0, b} << (8 * (i - 22)));
                        end
                    end
                end
            endcase
            if (!is_last) return;

            habs = hacc;
            case (kind)
                KIND_JPEG: ok = sof_done && wacc != 0 && hacc != 0;
                KIND_PNG:  ok = phase != SC_FAIL && seen >= 5'd24 && wacc != 0 && !wacc[31]
                               && hacc != 0 && !hacc[31];
                KIND_GIF:  ok = phase != SC_FAIL && seen >= 5'd10 && wacc != 0 && hacc != 0;
                default: begin
                    if (hacc[31]) habs = 32'd0 - hacc;
                    ok = phase != SC_FAIL && seen >= 5'd26 && wacc != 0 && !wacc[31]
                         && habs != 0 && !habs[31];
                end
            endcase
            r.found  = ok;
            r.width  = ok ? wacc[30:0] : 31'd0;
            r.height = ok ? habs[30:0] : 31'd0;
            expected_dims.push_back(r);
            pictures++;
            if (ok) found_count++;
            clear_picture();
        endfunction

        function void check_result(logic f, logic [30:0] w, logic [30:0] h);
            t_outcome e;
            if (expected_dims.size() == 0) begin
                $error("result beat with no picture pending: found %0d width %0d height %0d",
                       f, w, h);
                errors++;
                return;
            end
            e = expected_dims.pop_front();
            if (f !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, f);
                errors++;
            end
            if (w !== e.width) begin
                $error("width: expected %0d, actual %0d", e.width, w);
                errors++;
            end
            if (h !== e.height) begin
                $error("height: expected %0d, actual %0d", e.height, h);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    dim_scoreboard sb;
    logic [7:0]    pic[$];
    t_kind         cur_kind;
    bit            quiet;
    int            stall_request;
    int            random_bytes;
    int            kind_writes;

    image_header_dimension_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] pick_dim16();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'($urandom);
            default: return 16'($urandom_range(2000, 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_dim32();
        case ($urandom_range(6))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000 | $urandom;
            3: return $urandom;
            default: return $urandom_range(4000, 1);
        endcase
    endfunction

    function automatic logic [7:0] seg_marker();
        case ($urandom_range(7))
            0: return MK_DHT;
            1: return MK_JPG_EXT;
            2: return MK_DAC;
            3: return MK_DQT;
            4: return MK_COM;
            default: return MK_APP0 + 8'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [7:0] sof_marker();
        logic [7:0] m;
        m = MK_DHT;
        while (m == MK_DHT || m == MK_JPG_EXT || m == MK_DAC)
            m = MK_SOF_FIRST + 8'($urandom_range(15));
        return m;
    endfunction

    task automatic start_jpeg();
        pic.delete();
        pic.push_back(MK_PREFIX);
        pic.push_back(MK_SOI);
    endtask

    task automatic add_segment(input logic [7:0] marker, input logic [15:0] seg_len);
        pic.push_back(MK_PREFIX);
        pic.push_back(marker);
        pic.push_back(seg_len[15:8]);
        pic.push_back(seg_len[7:0]);
        if (seg_len >= 16'd2) begin
            repeat (seg_len - 16'd2) pic.push_back(8'($urandom));
        end
    endtask

    task automatic add_sof(input logic [7:0] marker, input logic [15:0] h,
                           input logic [15:0] w);
        pic.push_back(MK_PREFIX);
        pic.push_back(marker);
        pic.push_back(8'h00);
        pic.push_back(8'h11);
        pic.push_back(8'h08);
        pic.push_back(h[15:8]);
        pic.push_back(h[7:0]);
        pic.push_back(w[15:8]);
        pic.push_back(w[7:0]);
        pic.push_back(8'h03);
    endtask

    task automatic build_jpeg(input logic [15:0] h, input logic [15:0] w);
        start_jpeg();
        repeat ($urandom_range(4)) begin
            case ($urandom_range(15))
                0, 1: begin
                    pic.push_back(MK_PREFIX);
                    case ($urandom_range(2))
                        0: pic.push_back(MK_SOI);
                        1: pic.push_back(MK_TEM);
                        default: pic.push_back(MK_RST_FIRST + 8'($urandom_range(7)));
                    endcase
                end
                2, 3: repeat ($urandom_range(3, 1)) pic.push_back(MK_PREFIX);
                4: pic.push_back(8'($urandom_range(254)));
                5: add_segment(seg_marker(), 16'($urandom_range(1)));
                default: add_segment(seg_marker(), 16'($urandom_range(14, 2)));
            endcase
        end
        add_sof(sof_marker(), h, w);
        repeat ($urandom_range(3)) pic.push_back(8'($urandom));
    endtask

    task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int extra);
        int i;
        pic.delete();
        for (i = 0; i < 8; i++) pic.push_back(PNG_SIG[63 - 8 * i -: 8]);
        pic.push_back(8'h00);
        pic.push_back(8'h00);
        pic.push_back(8'h00);
        pic.push_back(8'h0D);
        for (i = 0; i < 4; i++) pic.push_back(PNG_IHDR[31 - 8 * i -: 8]);
        for (i = 3; i >= 0; i--) pic.push_back(w[8 * i +: 8]);
        for (i = 3; i >= 0; i--) pic.push_back(h[8 * i +: 8]);
        repeat (extra) pic.push_back(8'($urandom));
    endtask

    task automatic build_gif(input logic [15:0] w, input logic [15:0] h, input int extra);
        int i;
        pic.delete();
        for (i = 0; i < 4; i++) pic.push_back(GIF_MAGIC[31 - 8 * i -: 8]);
        pic.push_back(8'h39);
        pic.push_back(8'h61);
        pic.push_back(w[7:0]);
        pic.push_back(w[15:8]);
        pic.push_back(h[7:0]);
        pic.push_back(h[15:8]);
        repeat (extra) pic.push_back(8'($urandom));
    endtask

    task automatic build_bmp(input logic [31:0] w, input logic [31:0] h, input int extra);
        int i;
        pic.delete();
        pic.push_back(BMP_MAGIC[15:8]);
        pic.push_back(BMP_MAGIC[7:0]);
        repeat (16) pic.push_back(8'($urandom));
        for (i = 0; i < 4; i++) pic.push_back(w[8 * i +: 8]);
        for (i = 0; i < 4; i++) pic.push_back(h[8 * i +: 8]);
        repeat (extra) pic.push_back(8'($urandom));
    endtask

    task automatic build_random();
        int          n;
        logic [31:0] hgt;
        if ($urandom_range(19) == 0) begin
            pic.delete();
            repeat ($urandom_range(30, 1)) pic.push_back(8'($urandom));
            return;
        end
        case (cur_kind)
            KIND_JPEG: build_jpeg(pick_dim16(), pick_dim16());
            KIND_PNG:  build_png(pick_dim32(), pick_dim32(), $urandom_range(8));
            KIND_GIF:  build_gif(pick_dim16(), pick_dim16(), $urandom_range(8));
            default: begin
                case ($urandom_range(3))
                    0: hgt = 32'd0 - 32'($urandom_range(5000, 1));
                    1: hgt = 32'h8000_0000;
                    default: hgt = pick_dim32();
                endcase
                build_bmp(pick_dim32(), hgt, $urandom_range(8));
            end
        endcase
        case ($urandom_range(15))
            0, 1: begin
                n = $urandom_range(pic.size() - 1, 1);
                while (pic.size() > n) void'(pic.pop_back());
            end
            2: pic[$urandom_range(pic.size() - 1)] = 8'($urandom);
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        while (!quiet && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, is_last);
        random_bytes++;
    endtask

    task automatic send_picture();
        int i;
        for (i = 0; i < pic.size(); i++) push_byte(pic[i], i == pic.size() - 1);
    endtask

    task automatic send_partial(input int n);
        int i;
        for (i = 0; i < n && i < pic.size(); i++) push_byte(pic[i], 1'b0);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_dims.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_kind(input t_kind k);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_kind(k);
        cur_kind = k;
        kind_writes++;
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[61:31]);
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 10);
            end
        end
    end

    initial begin
        int    p;
        t_kind k;
        sb = new();
        cur_kind = KIND_JPEG;
        quiet = 1'b0;
        stall_request = 0;
        random_bytes = 0;
        kind_writes = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= KIND_JPEG;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // JPEG right after reset: extremes, standalone markers, fill bytes,
        // bad segment lengths, a long segment and a missing trailing byte.
        start_jpeg();
        add_sof(MK_SOF_FIRST, 16'hFFFF, 16'hFFFF);
        send_picture();
        start_jpeg();
        pic.push_back(MK_PREFIX);
        pic.push_back(MK_RST_FIRST);
        pic.push_back(MK_PREFIX);
        pic.push_back(MK_TEM);
        pic.push_back(MK_PREFIX);
        pic.push_back(MK_SOI);
        pic.push_back(MK_PREFIX);
        pic.push_back(MK_RST_LAST);
        repeat (3) pic.push_back(MK_PREFIX);
        add_segment(MK_APP0, 16'd2);
        add_segment(MK_DHT, 16'd5);
        add_sof(MK_SOF_LAST, 16'd1, 16'd1);
        send_picture();
        start_jpeg();
        add_sof(sof_marker(), 16'h0000, 16'h0123);
        send_picture();
        start_jpeg();
        add_segment(MK_DQT, 16'd1);
        add_sof(MK_SOF_FIRST, 16'd2, 16'd2);
        send_picture();
        start_jpeg();
        add_segment(MK_DQT, 16'd0);
        add_sof(MK_SOF_FIRST, 16'd2, 16'd2);
        send_picture();
        start_jpeg();
        add_segment(MK_APP0 + 8'd1, 16'h0100);
        add_sof(sof_marker(), 16'h0480, 16'h0640);
        send_picture();
        start_jpeg();
        add_sof(MK_SOF_FIRST, 16'd5, 16'd7);
        void'(pic.pop_back());
        send_picture();
        pic.delete();
        pic.push_back(MK_SOI);
        send_picture();
        build_jpeg(16'h0010, 16'h0020);
        send_picture();

        write_kind(KIND_PNG);
        build_png(32'h7FFF_FFFF, 32'd1, 0);
        send_picture();
        build_png(32'h8000_0000, 32'd5, 2);
        send_picture();
        build_png(32'd9, 32'hFFFF_FFFF, 0);
        send_picture();
        build_png(32'd9, 32'd9, 0);
        void'(pic.pop_back());
        send_picture();
        build_png(32'd1, 32'd1, 12);
        pic[13] = 8'h68;
        send_picture();

        write_kind(KIND_GIF);
        build_gif(16'hFFFF, 16'hFFFF, 0);
        send_picture();
        build_gif(16'h0000, 16'd3, 2);
        send_picture();
        build_gif(16'd4, 16'd4, 0);
        void'(pic.pop_back());
        send_picture();
        build_gif(16'd1, 16'd1, 25);
        pic[3] = 8'h37;
        send_picture();

        write_kind(KIND_BMP);
        build_bmp(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_picture();
        build_bmp(32'd16, 32'hFFFF_FFF0, 3);
        send_picture();
        build_bmp(32'h8000_0000, 32'd1, 0);
        send_picture();
        build_bmp(32'd1, 32'd1, 0);
        void'(pic.pop_back());
        send_picture();
        build_bmp(32'd640, 32'd480, 10);
        pic[1] = 8'h4E;
        send_picture();
        build_bmp(32'h7FFF_FFFF, 32'h8000_0001, 0);
        send_picture();
        // A kind write in the middle of a picture drops what was collected.
        build_bmp(32'd2, 32'd2, 0);
        send_partial(20);
        write_kind(KIND_JPEG);

        p = 0;
        while (p < 4 || random_bytes < STIM_BYTES) begin
            k = (p < 4) ? t_kind'(p) : t_kind'($urandom_range(3));
            if (p > 0 && $urandom_range(2) == 0) begin
                build_random();
                send_partial($urandom_range(pic.size(), 1));
            end
            write_kind(k);
            quiet = (p == 3);
            // Short GIF pictures while the result side holds off fill the block up.
            if (p == 2) stall_request = 300;
            repeat ($urandom_range(12, 6)) begin
                build_random();
                send_picture();
            end
            p++;
        end
        quiet = 1'b0;

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Parsed %0d pictures of all four kinds over %0d kind writes, %0d with dimensions.",
                 sb.pictures, kind_writes, sb.found_count);
        if (sb.errors == 0 && sb.expected_dims.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/hdp_pkg.sv
rtl/core/hdp_jpeg_walker.sv
rtl/core/hdp_fixed_fields.sv
rtl/core/image_header_dimension_parser_top.sv
tb/image_header_dimension_parser_top_test.sv
